// ===== design/swhl_pkg.sv =====
// ----------------------------------------------------------------------------
// swhl_pkg: shared definitions for the sliding-window high/low block
// Register indexes, configuration port widths and the control word that
// travels down the cell chain together with the running high and low.
// ----------------------------------------------------------------------------
package swhl_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_INCOMPLETE = 1'd1;

  // control word of the scan wave
  typedef struct packed {
    logic vld;   // wave is present at this stage
    logic full;  // window_length bars seen, current bar included
    logic emit;  // result is delivered at the end of the chain
  } swhl_wave_t;

endpackage

// ===== design/swhl_cell.sv =====
// ----------------------------------------------------------------------------
// swhl_cell: one history cell of the sliding-window chain
// Holds one past bar, shifted along on every accepted beat, and folds its
// bar into the running high/low of the scan wave when it lies in the window.
// ----------------------------------------------------------------------------
module swhl_cell #(
  parameter int PRICE_BITS = 32,
  parameter int CNT_W      = 7,
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  logic signed [PRICE_BITS-1:0] ent_hi_in,
  input  logic signed [PRICE_BITS-1:0] ent_lo_in,
  input  logic        [CNT_W-1:0]      span,
  input  swhl_pkg::swhl_wave_t         wave_in,
  input  logic signed [PRICE_BITS-1:0] acc_hi_in,
  input  logic signed [PRICE_BITS-1:0] acc_lo_in,
  output logic signed [PRICE_BITS-1:0] ent_hi_r,
  output logic signed [PRICE_BITS-1:0] ent_lo_r,
  output swhl_pkg::swhl_wave_t         wave_r,
  output logic signed [PRICE_BITS-1:0] acc_hi_r,
  output logic signed [PRICE_BITS-1:0] acc_lo_r
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic                         in_window;
  logic signed [PRICE_BITS-1:0] acc_hi_nxt;
  logic signed [PRICE_BITS-1:0] acc_lo_nxt;

  // cell IDX holds the bar IDX beats old
  assign in_window  = (MY_IDX < span);
  assign acc_hi_nxt = (in_window && (ent_hi_r > acc_hi_in)) ? ent_hi_r : acc_hi_in;
  assign acc_lo_nxt = (in_window && (ent_lo_r < acc_lo_in)) ? ent_lo_r : acc_lo_in;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_hi_r <= ent_hi_in;
      ent_lo_r <= ent_lo_in;
    end
    if (wave_in.vld) begin
      acc_hi_r <= acc_hi_nxt;
      acc_lo_r <= acc_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= '0;
    end else begin
      wave_r <= wave_in;
    end
  end

endmodule

// ===== design/sliding_window_high_low.sv =====
// Path to out_valid: start_r, the cell chain, pend_r, then out_valid_r.
// Bars are taken one at a time; the scan wave walks the
//   whole cell chain, one cell per cycle, before the next bar may shift in.
// A finished result waits in the output register while the next bar is taken.
// Reset (synchronous, rst_n low): clears bar count, handshake and wave state;
//   window_length returns to 1 and drop_incomplete to 0. No clearing pass.
// ----------------------------------------------------------------------------
// sliding_window_high_low: windowed maximum high and minimum low of bars
// Bars shift into a chain of history cells; a scan wave then folds the
// most recent span cells into a running high/low and lands in the output.
// ----------------------------------------------------------------------------
module sliding_window_high_low #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [PRICE_BITS-1:0]          in_bar_high,
  input  logic signed [PRICE_BITS-1:0]          in_bar_low,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [PRICE_BITS-1:0]          out_window_high,
  output logic signed [PRICE_BITS-1:0]          out_window_low,
  output logic                                  out_window_full,
  input  logic                                  cfg_we,
  input  logic        [swhl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [swhl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W = (CNT_W > swhl_pkg::CFG_DATA_W) ? CNT_W : swhl_pkg::CFG_DATA_W;

  // configuration
  logic [swhl_pkg::CFG_DATA_W-1:0] win_len_r;
  logic                            drop_inc_r;

  // control
  logic                         busy_r;
  logic [CNT_W-1:0]             bars_r;
  logic [CNT_W-1:0]             bars_nxt;
  logic [CNT_W-1:0]             span_r;
  logic [CNT_W-1:0]             span_nxt;
  logic [LEN_W-1:0]             len_ext;
  logic [CNT_W-1:0]             len_eff;
  logic                         full_nxt;
  logic                         accept;
  logic                         move;
  swhl_pkg::swhl_wave_t         start_r;
  logic signed [PRICE_BITS-1:0] seed_hi_r;
  logic signed [PRICE_BITS-1:0] seed_lo_r;
  swhl_pkg::swhl_wave_t         pend_r;
  logic signed [PRICE_BITS-1:0] pend_hi_r;
  logic signed [PRICE_BITS-1:0] pend_lo_r;
  logic                         out_valid_r;
  logic signed [PRICE_BITS-1:0] out_hi_r;
  logic signed [PRICE_BITS-1:0] out_lo_r;
  logic                         out_full_r;

  // chain taps: index 0 feeds the first cell
  logic signed [PRICE_BITS-1:0] ent_hi [MAX_WINDOW+1];
  logic signed [PRICE_BITS-1:0] ent_lo [MAX_WINDOW+1];
  logic signed [PRICE_BITS-1:0] acc_hi [MAX_WINDOW+1];
  logic signed [PRICE_BITS-1:0] acc_lo [MAX_WINDOW+1];
  swhl_pkg::swhl_wave_t         wave   [MAX_WINDOW+1];

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign move     = pend_r.vld && (!out_valid_r || !out_stall);

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    len_ext = LEN_W'(win_len_r);
    if (len_ext == '0) begin
      len_eff = CNT_W'(1);
    end else if (len_ext > LEN_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = len_ext[CNT_W-1:0];
    end
  end

  assign bars_nxt = (bars_r == CNT_W'(MAX_WINDOW)) ? bars_r : bars_r + CNT_W'(1);
  assign full_nxt = (bars_nxt >= len_eff);
  assign span_nxt = full_nxt ? len_eff : bars_nxt;

  assign ent_hi[0] = in_bar_high;
  assign ent_lo[0] = in_bar_low;
  assign acc_hi[0] = seed_hi_r;
  assign acc_lo[0] = seed_lo_r;
  assign wave[0]   = start_r;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swhl_cell #(
      .PRICE_BITS (PRICE_BITS),
      .CNT_W      (CNT_W),
      .IDX        (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (accept),
      .ent_hi_in (ent_hi[k]),
      .ent_lo_in (ent_lo[k]),
      .span      (span_r),
      .wave_in   (wave[k]),
      .acc_hi_in (acc_hi[k]),
      .acc_lo_in (acc_lo[k]),
      .ent_hi_r  (ent_hi[k+1]),
      .ent_lo_r  (ent_lo[k+1]),
      .wave_r    (wave[k+1]),
      .acc_hi_r  (acc_hi[k+1]),
      .acc_lo_r  (acc_lo[k+1])
    );
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      seed_hi_r <= in_bar_high;
      seed_lo_r <= in_bar_low;
      span_r    <= span_nxt;
    end
    if (wave[MAX_WINDOW].vld) begin
      pend_hi_r <= acc_hi[MAX_WINDOW];
      pend_lo_r <= acc_lo[MAX_WINDOW];
    end
    if (move && pend_r.emit) begin
      out_hi_r   <= pend_hi_r;
      out_lo_r   <= pend_lo_r;
      out_full_r <= pend_r.full;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= swhl_pkg::CFG_DATA_W'(1);
      drop_inc_r  <= 1'b0;
      busy_r      <= 1'b0;
      bars_r      <= '0;
      start_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          swhl_pkg::CFG_WINDOW_LENGTH:   win_len_r  <= cfg_wdata;
          swhl_pkg::CFG_DROP_INCOMPLETE: drop_inc_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      start_r.vld <= accept;
      if (accept) begin
        busy_r       <= 1'b1;
        bars_r       <= bars_nxt;
        start_r.full <= full_nxt;
        start_r.emit <= !(drop_inc_r && !full_nxt);
      end

      if (wave[MAX_WINDOW].vld) begin
        pend_r <= wave[MAX_WINDOW];
      end else if (move) begin
        pend_r.vld <= 1'b0;
        busy_r     <= 1'b0;
      end

      if (move && pend_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_window_high = out_hi_r;
  assign out_window_low  = out_lo_r;
  assign out_window_full = out_full_r;

`ifndef SYNTHESIS
  // a scan wave or a pending result only exists while a bar is in flight
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r.vld |-> busy_r)
    else $error("pending result while not busy");

  a_wave_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wave[MAX_WINDOW].vld |-> busy_r)
    else $error("scan wave finished while not busy");

  // an accepted bar always launches a wave that covers at least itself
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (start_r.vld && (span_r != '0)))
    else $error("accepted bar did not launch a scan wave");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sliding_window_high_low
// A table of directed bars and register settings runs first. Random bars
// follow in nine segments under changing window settings and idle patterns.
// Every accepted bar goes through a local window scan that predicts the
// result beat. Result beats are compared field by field against that queue.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WINDOW   = 64;
  localparam int PRICE_BITS   = 32;
  localparam int CLK_PERIOD   = 10;
  localparam int DRAIN_CYCLES = MAX_WINDOW + 6;
  localparam int HOLD_CYCLES  = 4 * (MAX_WINDOW + 2);
  localparam int STUCK_LIMIT  = 4000;
  localparam int NUM_SEGS     = 9;
  localparam int SEG_BARS     = 84;
  localparam int PICK_RANDOM  = -1;
  localparam int N_ROWS       = 22;

  typedef logic signed [PRICE_BITS-1:0] price_t;

  typedef struct packed {
    price_t high;
    price_t low;
    logic   full;
  } window_t;

  typedef enum logic {ROW_CFG, ROW_BAR} row_kind_e;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_TYPED} row_chk_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [6:0] len;
    logic       drop;
    price_t     high;
    price_t     low;
    row_chk_e   chk;
    window_t    want;
  } dir_row_t;

  localparam price_t P_MAX = 32'sh7FFF_FFFF;
  localparam price_t P_MIN = 32'sh8000_0000;

  // window length / drop flag per random segment
  localparam int LEN_PLAN  [NUM_SEGS] = '{64, 1, PICK_RANDOM, 127, 2, PICK_RANDOM, 63, 0,
                                          PICK_RANDOM};
  localparam int DROP_PLAN [NUM_SEGS] = '{1, 0, PICK_RANDOM, 1, 0, PICK_RANDOM, 0, 1,
                                          PICK_RANDOM};

  dir_row_t bench_rows [N_ROWS] = '{
    '{ROW_CFG, 7'd4,   1'b1, '0, '0, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, P_MAX, P_MIN, CHK_NONE, '0},
    '{ROW_BAR, 7'd0,   1'b0, P_MIN, P_MAX, CHK_NONE, '0},
    '{ROW_BAR, 7'd0,   1'b0, 32'sd0, 32'sd0, CHK_NONE, '0},
    '{ROW_BAR, 7'd0,   1'b0, 32'sd1, -32'sd1, CHK_TYPED, '{P_MAX, P_MIN, 1'b1}},
    '{ROW_BAR, 7'd0,   1'b0, 32'sd5, 32'sd5, CHK_TYPED, '{32'sd5, -32'sd1, 1'b1}},
    // zero length acts as one bar
    '{ROW_CFG, 7'd0,   1'b0, '0, '0, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, -32'sd3, -32'sd7, CHK_TYPED, '{-32'sd3, -32'sd7, 1'b1}},
    // oversize length clamps to the full history, only 7 bars held so far
    '{ROW_CFG, 7'd127, 1'b0, '0, '0, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, 32'sd2, 32'sd2, CHK_TYPED, '{P_MAX, P_MIN, 1'b0}},
    '{ROW_BAR, 7'd0,   1'b0, 32'sh0001_0000, 32'shFFFF_0000, CHK_PRED, '0},
    '{ROW_CFG, 7'd1,   1'b0, '0, '0, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, P_MIN, P_MAX, CHK_TYPED, '{P_MIN, P_MAX, 1'b1}},
    '{ROW_CFG, 7'd64,  1'b0, '0, '0, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, 32'sh1234_5678, 32'sh9ABC_DEF0, CHK_PRED, '0},
    '{ROW_CFG, 7'd2,   1'b1, '0, '0, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, P_MAX, P_MAX, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, P_MIN, P_MIN, CHK_TYPED, '{P_MAX, P_MIN, 1'b1}},
    // longer window mid-stream reaches back into held bars
    '{ROW_CFG, 7'd3,   1'b0, '0, '0, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, 32'sd0, 32'sd0, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, 32'shAAAA_AAAA, 32'sh5555_5555, CHK_PRED, '0},
    '{ROW_BAR, 7'd0,   1'b0, 32'sh5555_5555, 32'shAAAA_AAAA, CHK_PRED, '0}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  price_t                          in_bar_high = '0;
  price_t                          in_bar_low = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  price_t                          out_window_high;
  price_t                          out_window_low;
  logic                            out_window_full;
  logic                            cfg_we = 1'b0;
  logic [swhl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [swhl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // local copy of the block state
  price_t     high_hist [MAX_WINDOW];
  price_t     low_hist [MAX_WINDOW];
  int         bars_held = 0;
  int         next_slot = 0;
  logic [6:0] len_reg = 7'd1;
  logic       drop_reg = 1'b0;

  window_t    window_q [$];
  int         err_cnt = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         stuck_cnt = 0;

  sliding_window_high_low #(
    .MAX_WINDOW(MAX_WINDOW),
    .PRICE_BITS(PRICE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_bar_high    (in_bar_high),
    .in_bar_low     (in_bar_low),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_high(out_window_high),
    .out_window_low (out_window_low),
    .out_window_full(out_window_full),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Store the bar, then fold the most recent span bars into high/low.
  // Returns 0 when the result is held back for an incomplete window.
  function automatic bit scan_window(input price_t h, input price_t l, output window_t res);
    int     len;
    int     span;
    int     cur;
    int     slot;
    int     k;
    price_t hi;
    price_t lo;
    logic   full;
    len = (len_reg == 0) ? 1 : ((len_reg > MAX_WINDOW) ? MAX_WINDOW : int'(len_reg));
    cur = next_slot;
    high_hist[cur] = h;
    low_hist[cur] = l;
    next_slot = (cur + 1) % MAX_WINDOW;
    if (bars_held < MAX_WINDOW) bars_held++;
    full = (bars_held >= len);
    span = full ? len : bars_held;
    hi = h;
    lo = l;
    for (k = 1; k < span; k++) begin
      slot = (cur + MAX_WINDOW - k) % MAX_WINDOW;
      if (high_hist[slot] > hi) hi = high_hist[slot];
      if (low_hist[slot] < lo) lo = low_hist[slot];
    end
    res = '{hi, lo, full};
    return !(drop_reg && !full);
  endfunction

  function automatic price_t price_corner();
    case ($urandom_range(3))
      0: return P_MAX;
      1: return P_MIN;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic write_cfg(input logic [6:0] len, input logic drop);
    cfg_we    <= 1'b1;
    cfg_index <= swhl_pkg::CFG_WINDOW_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_index <= swhl_pkg::CFG_DROP_INCOMPLETE;
    cfg_wdata <= swhl_pkg::CFG_DATA_W'(drop);
    @(posedge clk);
    cfg_we   <= 1'b0;
    len_reg  = len;
    drop_reg = drop;
  endtask

  // Stop offering, wait out every pending result, then a tail of cycles.
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (window_q.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic send_bar(input price_t h, input price_t l, input row_chk_e chk,
                          input window_t want);
    window_t pred;
    bit      fires;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_bar_high <= h;
    in_bar_low  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fires = scan_window(h, l, pred);
    if (chk == CHK_TYPED) window_q.push_back(want);
    else if (chk == CHK_PRED && fires) window_q.push_back(pred);
  endtask

  // receiver: random stall, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    window_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (window_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got high %h low %h full %b",
                 $time, out_window_high, out_window_low, out_window_full);
        err_cnt++;
      end else begin
        want = window_q.pop_front();
        if (out_window_high !== want.high) begin
          $display("%0t: window_high expected %h got %h", $time, want.high, out_window_high);
          err_cnt++;
        end
        if (out_window_low !== want.low) begin
          $display("%0t: window_low expected %h got %h", $time, want.low, out_window_low);
          err_cnt++;
        end
        if (out_window_full !== want.full) begin
          $display("%0t: window_full expected %b got %b", $time, want.full, out_window_full);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt == STUCK_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  initial begin : stimulus
    price_t     h;
    price_t     l;
    price_t     level;
    logic [6:0] len;
    logic       drop;
    int         seg;
    int         n;
    level = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 22;
    stall_pct     = 79;

    foreach (bench_rows[i]) begin
      if (bench_rows[i].kind == ROW_CFG) begin
        settle(DRAIN_CYCLES);
        write_cfg(bench_rows[i].len, bench_rows[i].drop);
      end else begin
        send_bar(bench_rows[i].high, bench_rows[i].low, bench_rows[i].chk,
                 bench_rows[i].want);
      end
    end

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 3)
        0: begin send_idle_pct = 22; stall_pct = 79; end
        1: begin send_idle_pct = 79; stall_pct = 22; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      len  = (LEN_PLAN[seg] == PICK_RANDOM) ? 7'($urandom_range(1, MAX_WINDOW))
                                            : 7'(LEN_PLAN[seg]);
      drop = (DROP_PLAN[seg] == PICK_RANDOM) ? 1'($urandom_range(1)) : 1'(DROP_PLAN[seg]);
      settle(DRAIN_CYCLES);
      write_cfg(len, drop);
      for (n = 0; n < SEG_BARS; n++) begin
        // fill the block against a held-off receiver
        if ((seg == 1 || seg == 7) && n == 20) hold_req++;
        if ($urandom_range(99) < 3) settle(0);
        case ($urandom_range(3))
          0: begin
            h = price_t'($urandom);
            l = price_t'($urandom);
          end
          1: begin
            h = price_corner();
            l = price_corner();
          end
          default: begin
            // tight bars around a drifting level keep compares close
            level = level + price_t'($urandom_range(0, 8191)) - 32'sd4096;
            h = level + price_t'($urandom_range(0, 4095));
            l = level - price_t'($urandom_range(0, 4095));
          end
        endcase
        send_bar(h, l, CHK_PRED, '0);
      end
    end

    settle(DRAIN_CYCLES);
    if (window_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, window_q.size());
    if (err_cnt == 0 && window_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/swhl_pkg.sv
design/swhl_cell.sv
design/sliding_window_high_low.sv
bench/tb_top.sv
